// ===== rtl/assert_macros.svh =====
// assertion macros shared by the loader rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("assertion failed");

`else

`define ASSERT_PROP(label, clk, rstn, prop)

`define ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

// ===== rtl/ihex_pkg.sv =====
// types and constants of the hex record loader
package ihex_pkg;

    localparam int ADDR_BITS   = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] DIGIT_TEN  = 8'd10;

    localparam logic [2:0] HDR_LAST_DIGIT = 3'd7;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_FORMAT = 2'd2,
        KIND_TYPE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]           result_kind;
        logic [ADDR_BITS-1:0] write_address;
        logic [7:0]           write_data;
    } out_beat_t;

    // classified character handed from front to back
    typedef struct packed {
        logic       eoi;
        logic       is_colon;
        logic       is_lf;
        logic [3:0] digit;
    } cls_t;

endpackage

// ===== rtl/ihex_front.sv =====
// front stage: accepts input beats and classifies each character
module ihex_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ihex_pkg::in_beat_t s_data,
    output logic              f_valid,
    input  logic              f_ready,
    output ihex_pkg::cls_t    f_item
);

    logic           f_valid_reg;
    logic           f_valid_next;
    ihex_pkg::cls_t f_item_reg;
    ihex_pkg::cls_t f_item_next;
    logic [7:0]     c;
    logic [7:0]     dval;

    assign c       = s_data.char_byte;
    assign s_ready = !f_valid_reg || f_ready;

    always_comb begin
        if (c inside {[ihex_pkg::CH_LOWER_A:ihex_pkg::CH_LOWER_F]}) begin
            dval = c - ihex_pkg::CH_LOWER_A + ihex_pkg::DIGIT_TEN;
        end else if (c inside {[ihex_pkg::CH_UPPER_A:ihex_pkg::CH_UPPER_F]}) begin
            dval = c - ihex_pkg::CH_UPPER_A + ihex_pkg::DIGIT_TEN;
        end else begin
            // anything else keeps the low nibble of its offset from '0'
            dval = c - ihex_pkg::CH_ZERO;
        end
    end

    always_comb begin
        f_valid_next = f_valid_reg;
        f_item_next  = f_item_reg;
        if (f_ready) begin
            f_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            f_valid_next         = 1'b1;
            f_item_next.eoi      = s_data.operation;
            f_item_next.is_colon = (c == ihex_pkg::CH_COLON);
            f_item_next.is_lf    = (c == ihex_pkg::CH_LF);
            f_item_next.digit    = dval[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
        f_item_reg <= f_item_next;
    end

    assign f_valid = f_valid_reg;
    assign f_item  = f_item_reg;

endmodule

// ===== rtl/ihex_queue.sv =====
// short queue of classified characters between front and back
`include "assert_macros.svh"

module ihex_queue #(
    parameter int DEPTH = ihex_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  ihex_pkg::cls_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output ihex_pkg::cls_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ihex_pkg::cls_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    `ASSERT_NEVER(a_count_in_range, aclk, aresetn, count_reg > CNT_W'(DEPTH))
    `ASSERT_PROP(a_push_pop_balance, aclk, aresetn,
        (push && pop) |=> (count_reg == $past(count_reg)))

endmodule

// ===== rtl/ihex_back.sv =====
// back end: record state machine that turns characters into results
`include "assert_macros.svh"

module ihex_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  ihex_pkg::cls_t      q_item,
    output logic                m_valid,
    input  logic                m_ready,
    output ihex_pkg::out_beat_t m_data
);

    localparam int AW = ihex_pkg::ADDR_BITS;

    typedef enum logic [2:0] {
        PH_COLON,
        PH_HEADER,
        PH_DATA,
        PH_SKIP,
        PH_HALT
    } phase_t;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [2:0]          hdr_cnt_reg;
    logic [2:0]          hdr_cnt_next;
    logic [31:0]         hdr_shift_reg;
    logic [31:0]         hdr_shift_next;
    logic [7:0]          bytes_left_reg;
    logic [7:0]          bytes_left_next;
    logic [AW-1:0]       next_addr_reg;
    logic [AW-1:0]       next_addr_next;
    logic [3:0]          high_nib_reg;
    logic [3:0]          high_nib_next;
    logic                nib_pend_reg;
    logic                nib_pend_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    ihex_pkg::out_beat_t m_data_reg;
    ihex_pkg::out_beat_t m_data_next;

    logic                pop;
    logic                emit;
    ihex_pkg::kind_t     emit_kind;
    logic [31:0]         shift_in;
    logic [7:0]          rec_count;
    logic [7:0]          rec_type;
    logic [7:0]          bytes_dec;

    assign q_ready   = !m_valid_reg || m_ready;
    assign pop       = q_valid && q_ready;
    assign shift_in  = {hdr_shift_reg[27:0], q_item.digit};
    assign rec_count = shift_in[31:24];
    assign rec_type  = shift_in[7:0];
    assign bytes_dec = bytes_left_reg - 8'd1;

    always_comb begin
        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        hdr_shift_next  = hdr_shift_reg;
        bytes_left_next = bytes_left_reg;
        next_addr_next  = next_addr_reg;
        high_nib_next   = high_nib_reg;
        nib_pend_next   = nib_pend_reg;
        emit            = 1'b0;
        emit_kind       = ihex_pkg::KIND_DONE;
        m_data_next     = m_data_reg;

        if (pop) begin
            if (q_item.eoi || (phase_reg == PH_SKIP && q_item.is_lf)) begin
                // back to line start
                phase_next      = PH_COLON;
                hdr_cnt_next    = '0;
                hdr_shift_next  = '0;
                bytes_left_next = '0;
                next_addr_next  = '0;
                high_nib_next   = '0;
                nib_pend_next   = 1'b0;
                emit            = q_item.eoi && (phase_reg inside
                                  {PH_COLON, PH_HEADER, PH_DATA, PH_SKIP});
                emit_kind       = ihex_pkg::KIND_DONE;
            end else begin
                case (phase_reg)
                    PH_COLON: begin
                        if (q_item.is_colon) begin
                            phase_next     = PH_HEADER;
                            hdr_cnt_next   = '0;
                            hdr_shift_next = '0;
                        end else begin
                            phase_next = PH_HALT;
                            emit       = 1'b1;
                            emit_kind  = ihex_pkg::KIND_FORMAT;
                        end
                    end
                    PH_HEADER: begin
                        hdr_shift_next = shift_in;
                        if (hdr_cnt_reg != ihex_pkg::HDR_LAST_DIGIT) begin
                            hdr_cnt_next = hdr_cnt_reg + 3'd1;
                        end else begin
                            hdr_cnt_next = '0;
                            if (rec_type == ihex_pkg::REC_DATA) begin
                                bytes_left_next = rec_count;
                                next_addr_next  = shift_in[8 +: AW];
                                nib_pend_next   = 1'b0;
                                phase_next      = (rec_count == 8'd0) ? PH_SKIP : PH_DATA;
                            end else begin
                                phase_next = PH_HALT;
                                emit       = 1'b1;
                                emit_kind  = (rec_type == ihex_pkg::REC_EOF) ?
                                             ihex_pkg::KIND_DONE : ihex_pkg::KIND_TYPE;
                            end
                        end
                    end
                    PH_DATA: begin
                        if (!nib_pend_reg) begin
                            high_nib_next = q_item.digit;
                            nib_pend_next = 1'b1;
                        end else begin
                            nib_pend_next   = 1'b0;
                            next_addr_next  = next_addr_reg + 1'b1;
                            bytes_left_next = bytes_dec;
                            if (bytes_dec == 8'd0) begin
                                phase_next = PH_SKIP;
                            end
                            emit      = 1'b1;
                            emit_kind = ihex_pkg::KIND_WRITE;
                        end
                    end
                    default: begin
                        // skip phase without line feed, or halted
                    end
                endcase
            end
        end

        if (emit) begin
            m_data_next.result_kind = emit_kind;
            if (emit_kind == ihex_pkg::KIND_WRITE) begin
                m_data_next.write_address = next_addr_reg;
                m_data_next.write_data    = {high_nib_reg, q_item.digit};
            end else begin
                m_data_next.write_address = '0;
                m_data_next.write_data    = '0;
            end
        end

        m_valid_next = emit || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_COLON;
            hdr_cnt_reg    <= '0;
            hdr_shift_reg  <= '0;
            bytes_left_reg <= '0;
            next_addr_reg  <= '0;
            high_nib_reg   <= '0;
            nib_pend_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            hdr_shift_reg  <= hdr_shift_next;
            bytes_left_reg <= bytes_left_next;
            next_addr_reg  <= next_addr_next;
            high_nib_reg   <= high_nib_next;
            nib_pend_reg   <= nib_pend_next;
            m_valid_reg    <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_PROP(a_nonwrite_zero_payload, aclk, aresetn,
        (m_valid_reg && m_data_reg.result_kind != ihex_pkg::KIND_WRITE) |->
        (m_data_reg.write_address == '0 && m_data_reg.write_data == '0))
    `ASSERT_PROP(a_halt_is_silent, aclk, aresetn,
        (phase_reg == PH_HALT && pop) |=>
        (m_valid_reg == ($past(m_valid_reg) && !$past(m_ready))))
    `ASSERT_PROP(a_hdr_count_idle, aclk, aresetn,
        (phase_reg != PH_HEADER) |-> (hdr_cnt_reg == '0))

endmodule

// ===== rtl/intel_hex_record_loader_top.sv =====
// top level of the hex record loader: front, queue and back end
//
//  port group          dir   beat payload
//  s_valid/s_ready     in    in_beat_t: operation, char_byte
//  m_valid/m_ready     out   out_beat_t: result_kind, write_address, write_data
//
//  one character per cycle sustained while m_ready is high; the back end's record state
//  update is the loop that sets this figure
//  an accepted beat reaches a result via the front reg, a queue slot and the output reg
//  reset is synchronous on aresetn; the block is ready on the first cycle after it
//  while m_ready is low the queue absorbs up to QUEUE_DEPTH beats plus the front register
module intel_hex_record_loader_top #(
    parameter int QUEUE_DEPTH = ihex_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ihex_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ihex_pkg::out_beat_t m_data
);

    logic           f_valid;
    logic           f_ready;
    ihex_pkg::cls_t f_item;
    logic           q_valid;
    logic           q_ready;
    ihex_pkg::cls_t q_item;

    ihex_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .f_valid (f_valid),
        .f_ready (f_ready),
        .f_item  (f_item)
    );

    ihex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    ihex_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
